>>> sv/per_frame_hold_time_tracker_unit_macros.svh
// Assertion helpers
`ifndef PER_FRAME_HOLD_TIME_TRACKER_UNIT_MACROS_SVH
`define PER_FRAME_HOLD_TIME_TRACKER_UNIT_MACROS_SVH
`define PFH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("lbl");
`define PFH_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error("lbl");
`endif

>>> sv/pfhtt_pkg.sv
package pfhtt_pkg;
  localparam int unsigned Channels = 256;
  localparam int unsigned ChW = $clog2(Channels);
  localparam logic [16:0] FracOne = 17'd65536;
  typedef enum logic [2:0] {
    MODE_FRAME = 3'd0, MODE_PRESS = 3'd1, MODE_RELEASE = 3'd2,
    MODE_ACT = 3'd3, MODE_DEACT = 3'd4, MODE_QUERY = 3'd5,
    MODE_UNUSED6 = 3'd6, MODE_UNUSED7 = 3'd7
  } mode_e;
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT
  } state_e;
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  channel;
    logic [63:0] event_time;
  } req_t;
  typedef struct packed {
    logic        is_held;
    logic        held_clean;
    logic        was_released;
    logic [16:0] hold_fraction;
  } res_t;
endpackage

>>> sv/pfhtt_ram.sv
module pfhtt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/pfhtt_front.sv
module pfhtt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  pfhtt_pkg::req_t req_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output pfhtt_pkg::req_t q_req_o
);
  logic [1:0] cnt_q, cnt_d;
  logic       rp_q, rp_d, wp_q, wp_d;
  pfhtt_pkg::req_t buf_q [2];
  logic push, pop, keep;
  always_comb begin
    keep = (req_i.mode <= pfhtt_pkg::MODE_QUERY);
    ready_o = (cnt_q != 2'd2);
    push = valid_i && ready_o && keep;
    pop = q_valid_o && q_ready_i;
    q_valid_o = (cnt_q != 2'd0);
    q_req_o = buf_q[rp_q];
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    rp_d = rp_q ^ pop;
    wp_d = wp_q ^ push;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rp_q <= 1'b0; wp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; rp_q <= rp_d; wp_q <= wp_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= req_i;
  end
endmodule

>>> sv/pfhtt_back.sv
`include "per_frame_hold_time_tracker_unit_macros.svh"
module pfhtt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  pfhtt_pkg::req_t req_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output pfhtt_pkg::res_t res_o
);
  pfhtt_pkg::state_e st_q, st_d;
  pfhtt_pkg::req_t   r_q;
  logic [pfhtt_pkg::Channels-1:0] prs_q, rel_q;
  logic [63:0] prev_q, cur_q;
  logic        act_q;
  logic [63:0] ps_rd, ac_rd;
  logic        we;
  logic [63:0] ac_wd;
  logic [63:0] acc, since, tot, dur, rem_q;
  logic [16:0] q_q;
  logic [4:0]  it_q;
  logic        ok, pf, fresh;
  logic [pfhtt_pkg::ChW-1:0] idx;
  logic [64:0] sum, rr;
  logic [63:0] from, upto;
  pfhtt_pkg::res_t res_q;
  assign idx = r_q.channel[pfhtt_pkg::ChW-1:0];
  assign ok = ({1'b0, r_q.channel} < 9'(pfhtt_pkg::Channels));
  assign pf = prs_q[idx] && ok;
  assign fresh = rel_q[idx];
  assign acc = fresh ? ac_rd : 64'd0;
  assign dur = cur_q - prev_q;
  pfhtt_ram #(.Width(64), .Depth(pfhtt_pkg::Channels)) u_ps (
    .clk_i, .we_i(st_q == pfhtt_pkg::S_EXEC && r_q.mode == pfhtt_pkg::MODE_PRESS && act_q
      && ok && !prs_q[idx]),
    .waddr_i(idx), .wdata_i(r_q.event_time), .raddr_i(idx), .rdata_o(ps_rd));
  pfhtt_ram #(.Width(64), .Depth(pfhtt_pkg::Channels)) u_ac (
    .clk_i, .we_i(we), .waddr_i(idx), .wdata_i(ac_wd),
    .raddr_i(idx), .rdata_o(ac_rd));
  always_comb begin
    since = (ps_rd > prev_q) ? ps_rd : prev_q;
    upto = (r_q.event_time < cur_q) ? r_q.event_time : cur_q;
    from = since;
    sum = {1'b0, acc} + {1'b0, upto - from};
    ac_wd = (upto > from) ? (sum[64] ? '1 : sum[63:0]) : acc;
    we = st_q == pfhtt_pkg::S_EXEC && r_q.mode == pfhtt_pkg::MODE_RELEASE && act_q && pf;
    sum = (pf && cur_q > since) ? {1'b0, acc} + {1'b0, cur_q - since} : {1'b0, acc};
    tot = sum[64] ? '1 : sum[63:0];
    rr = {rem_q, 1'b0};
  end
  always_comb begin
    st_d = st_q;
    case (st_q)
      pfhtt_pkg::S_IDLE: if (valid_i) st_d = pfhtt_pkg::S_READ;
      pfhtt_pkg::S_READ: st_d = pfhtt_pkg::S_EXEC;
      pfhtt_pkg::S_EXEC: st_d = (r_q.mode == pfhtt_pkg::MODE_QUERY) ?
                                pfhtt_pkg::S_DIV : pfhtt_pkg::S_IDLE;
      pfhtt_pkg::S_DIV: if (it_q == 5'd0) st_d = pfhtt_pkg::S_OUT;
      pfhtt_pkg::S_OUT: if (res_ready_i) st_d = pfhtt_pkg::S_IDLE;
      default: st_d = pfhtt_pkg::S_IDLE;
    endcase
  end
  always_comb begin
    ready_o = (st_q == pfhtt_pkg::S_IDLE);
    res_valid_o = (st_q == pfhtt_pkg::S_OUT);
    res_o = res_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pfhtt_pkg::S_IDLE; prs_q <= '0; rel_q <= '0;
      prev_q <= '0; cur_q <= '0; act_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == pfhtt_pkg::S_EXEC) begin
        case (r_q.mode)
          pfhtt_pkg::MODE_FRAME: begin
            prev_q <= cur_q; cur_q <= r_q.event_time; rel_q <= '0;
          end
          pfhtt_pkg::MODE_PRESS: if (act_q && ok) prs_q[idx] <= 1'b1;
          pfhtt_pkg::MODE_RELEASE: if (act_q && pf) begin
            prs_q[idx] <= 1'b0; rel_q[idx] <= 1'b1;
          end
          pfhtt_pkg::MODE_ACT: act_q <= 1'b1;
          pfhtt_pkg::MODE_DEACT: act_q <= 1'b0;
          default: act_q <= act_q;
        endcase
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) r_q <= req_i;
    if (st_q == pfhtt_pkg::S_EXEC) begin
      res_q.is_held <= pf;
      res_q.held_clean <= pf && (acc == 64'd0);
      res_q.was_released <= ok && rel_q[idx];
      rem_q <= tot; q_q <= '0;
      if (dur != 64'd0 && tot >= dur && ok) begin
        res_q.hold_fraction <= pfhtt_pkg::FracOne; it_q <= 5'd0;
      end else if (dur == 64'd0 || !ok) begin
        res_q.hold_fraction <= '0; it_q <= 5'd0;
      end else begin
        res_q.hold_fraction <= '0; it_q <= 5'd16;
      end
    end
    if (st_q == pfhtt_pkg::S_DIV && it_q != 5'd0) begin
      it_q <= it_q - 5'd1;
      if (rr >= {1'b0, dur}) begin
        rem_q <= 64'(rr - {1'b0, dur}); q_q <= {q_q[15:0], 1'b1};
      end else begin
        rem_q <= rr[63:0]; q_q <= {q_q[15:0], 1'b0};
      end
      if (it_q == 5'd1) res_q.hold_fraction <= {q_q[15:0], rr >= {1'b0, dur}};
    end
  end
  `PFH_ASSERT(a_out_hold, res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
  `PFH_NEVER(a_frac_range, res_valid_o && res_o.hold_fraction > pfhtt_pkg::FracOne)
  `PFH_ASSERT(a_no_take_busy, st_q != pfhtt_pkg::S_IDLE |-> !ready_o)
endmodule

>>> sv/per_frame_hold_time_tracker_unit.sv
// After dequeue a request passes S_READ and S_EXEC; a query also passes S_DIV and S_OUT.
// The back end takes a new request only once idle again; the front end buffers up to two.
// Divider: restoring radix-2, one quotient bit a cycle.
// Frame start clears accumulated time through the per-channel released flags.
// Reset: rst_ni asynchronous active low; all channels unpressed, inactive.
module per_frame_hold_time_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // channel[7:0], event_time[71:8]
  input  logic [2:0]  s_axis_tuser_i,  // mode[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // is_held, held_clean, was_released, hold_fraction[19:3]
);
  pfhtt_pkg::req_t in_req, q_req;
  pfhtt_pkg::res_t res;
  logic q_valid, q_ready;
  assign in_req = '{mode: s_axis_tuser_i, channel: s_axis_tdata_i[7:0],
                    event_time: s_axis_tdata_i[71:8]};
  pfhtt_front u_front (.clk_i, .rst_ni, .valid_i(s_axis_tvalid_i),
    .ready_o(s_axis_tready_o), .req_i(in_req), .q_valid_o(q_valid),
    .q_ready_i(q_ready), .q_req_o(q_req));
  pfhtt_back u_back (.clk_i, .rst_ni, .valid_i(q_valid), .ready_o(q_ready),
    .req_i(q_req), .res_valid_o(m_axis_tvalid_o), .res_ready_i(m_axis_tready_i),
    .res_o(res));
  assign m_axis_tdata_o = {4'd0, res.hold_fraction, res.was_released,
                           res.held_clean, res.is_held};
endmodule
